FILE: hw/rtl/omr_pkg.sv
// Package for the optical Morse receiver: shared widths, register indexes
// and the Morse letter lookup. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package omr_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_UNIT      = 3'd1;
    localparam logic [2:0] REG_STABLE    = 3'd2;
    localparam logic [2:0] REG_DOT_MAX   = 3'd3;
    localparam logic [2:0] REG_DASH_MAX  = 3'd4;
    localparam logic [2:0] REG_LETTER    = 3'd5;
    localparam logic [2:0] REG_WORD      = 3'd6;
    localparam logic [2:0] REG_PHRASE    = 3'd7;

    localparam int          MAX_SYMBOLS = 5;
    localparam logic [6:0]  CHAR_SPACE  = 7'd32;
    localparam logic [6:0]  CHAR_NL     = 7'd10;
    localparam logic [3:0]  RUN_MAX     = 4'd15;

    // Index = (1 << length) - 2 + pattern, bit i of pattern is symbol i (1 = dash)
    localparam logic [6:0] CODE_TABLE [0:61] = '{
        7'd69, 7'd84,
        7'd73, 7'd78, 7'd65, 7'd77,
        7'd83, 7'd68, 7'd82, 7'd71, 7'd85, 7'd75, 7'd87, 7'd79,
        7'd72, 7'd66, 7'd76, 7'd90, 7'd70, 7'd67, 7'd80, 7'd0,
        7'd86, 7'd88, 7'd0,  7'd81, 7'd0,  7'd89, 7'd74, 7'd0,
        7'd53, 7'd54, 7'd0,  7'd55, 7'd0,  7'd0,  7'd0,  7'd56,
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd57,
        7'd52, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
        7'd51, 7'd0,  7'd0,  7'd0,  7'd50, 7'd0,  7'd49, 7'd48
    };

    // Letter for a collected pattern; zero means nothing to send
    function automatic logic [6:0] letter_of(input logic [2:0] cnt, input logic [4:0] pat);
        logic [5:0] idx;
        logic [6:0] c;
        idx = 6'((7'd1 << cnt) - 7'd2 + {2'b00, pat});
        c   = 7'd0;
        if (cnt != 3'd0 && cnt <= 3'(MAX_SYMBOLS)) begin
            c = CODE_TABLE[idx];
            if (cnt == 3'(MAX_SYMBOLS) && $countones(pat) <= 1) begin
                c = 7'd0;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/optical_morse_receiver.sv
// Optical Morse receiver top level: debounce, run timing, shared unit
// divider and letter assembly. Depends on omr_pkg.
//
// Usage: one light sample word per item on the s_axis channel (tdata holds
// adc_sample, tuser holds sample_ok). Each item yields zero, one or two
// character words on m_axis (tdata holds out_char, tlast marks the last
// character of the item). Registers are to be written on the i_cfg_* port only
// while idle; the block itself does not enforce this. After a sample is taken,
// the block passes a debounce and bookkeeping step, then up to two run-to-unit
// divisions on the one shared restoring divider, each of TICK_COUNT_BITS+2
// divide steps and an evaluate step, then sends one character per cycle while
// m_axis_tready takes it, or passes straight through the output state when
// there is none. No new sample is taken until the last one is through.
// s_axis_tready is high only while the block waits for a sample.
// Reset (synchronous, active low) restores register defaults, darkness,
// empty counters and an empty letter. If the receiver stalls, the pending
// character holds on m_axis and no new sample is taken.
`timescale 1ns / 1ps
`default_nettype none
module optical_morse_receiver #(
    parameter int SAMPLE_BITS     = 12,
    parameter int TICK_COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_addr,
    input  wire logic [11:0]           i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // adc_sample
    input  wire logic                  s_axis_tuser,                // sample_ok
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output      logic [7:0]            m_axis_tdata,  // out_char
    output      logic                  m_axis_tlast   // last_of_run
);

    localparam int TB  = TICK_COUNT_BITS;
    localparam int UW  = TB + 2;           // dividend and quotient width
    localparam int CW  = $clog2(UW + 1);
    localparam logic [TB-1:0] TICK_MAX = '1;

    typedef enum logic [2:0] {S_IDLE, S_DEB, S_DIV, S_EVAL, S_OUT} t_state;
    typedef enum logic [1:0] {OP_OFF_LIGHT, OP_ON, OP_PHRASE} t_op;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [11:0] r_thr;
    logic [7:0]  r_unit;
    logic [3:0]  r_stable;
    logic [5:0]  r_dot, r_dash, r_letter, r_word, r_phrase;

    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_ok;
    logic       r_light, n_light, r_prev, n_prev, r_pdone, n_pdone;
    logic [3:0] r_above, n_above, r_below, n_below;
    logic [TB-1:0] r_on, n_on, r_off, n_off;
    logic [4:0] r_pat, n_pat;
    logic [2:0] r_scnt, n_scnt;

    logic [UW-1:0] r_dq, n_dq;
    logic [8:0]    r_rem, n_rem, r_dv, n_dv;
    logic [CW-1:0] r_bits, n_bits;

    logic [6:0] r_c0, n_c0, r_c1, n_c1, c;
    logic [1:0] r_ec, n_ec;
    logic       r_idx, n_idx;

    logic [7:0]    u;
    logic [9:0]    sh;
    logic [UW-1:0] q;
    logic          is_dash;

    assign u = (r_unit == 8'd0) ? 8'd1 : r_unit;
    assign q = r_dq;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT) && (r_ec != 2'd0);
    assign m_axis_tdata  = {1'b0, r_idx ? r_c1 : r_c0};
    assign m_axis_tlast  = (2'(r_idx) + 2'd1 == r_ec);

    // Sequencer: debounce, run timing, divider steps and letter handling
    always_comb begin
        n_state = r_state;  n_op = r_op;
        n_light = r_light;  n_prev = r_prev;  n_pdone = r_pdone;
        n_above = r_above;  n_below = r_below;
        n_on = r_on;  n_off = r_off;  n_pat = r_pat;  n_scnt = r_scnt;
        n_dq = r_dq;  n_rem = r_rem;  n_dv = r_dv;  n_bits = r_bits;
        n_c0 = r_c0;  n_c1 = r_c1;  n_ec = r_ec;  n_idx = r_idx;
        sh = '0;  c = '0;  is_dash = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_DEB;
                    n_ec    = 2'd0;
                    n_idx   = 1'b0;
                end
            end
            S_DEB: begin
                if (r_ok) begin
                    if (r_sample > SAMPLE_BITS'(r_thr)) begin
                        if (r_above < omr_pkg::RUN_MAX) n_above = r_above + 4'd1;
                        n_below = 4'd0;
                        if (!r_light && n_above >= r_stable) n_light = 1'b1;
                    end else begin
                        if (r_below < omr_pkg::RUN_MAX) n_below = r_below + 4'd1;
                        n_above = 4'd0;
                        if (r_light && n_below >= r_stable) n_light = 1'b0;
                    end
                end
                n_prev  = n_light;
                n_dv    = {u, 1'b0};
                n_rem   = '0;
                n_bits  = CW'(UW);
                n_state = S_OUT;
                if (n_light) begin
                    if (r_on != TICK_MAX) n_on = r_on + 1'b1;
                    if (!r_prev && r_off != '0) begin
                        n_dq    = {1'b0, r_off, 1'b0} + UW'(u);
                        n_op    = OP_OFF_LIGHT;
                        n_state = S_DIV;
                    end
                end else begin
                    if (r_off != TICK_MAX) n_off = r_off + 1'b1;
                    if (r_prev && r_on != '0) begin
                        n_dq    = {1'b0, r_on, 1'b0} + UW'(u);
                        n_op    = OP_ON;
                        n_state = S_DIV;
                    end else if (!r_pdone) begin
                        n_dq    = {1'b0, n_off, 1'b0} + UW'(u);
                        n_op    = OP_PHRASE;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // One restoring divide step per cycle
                sh = {r_rem, r_dq[UW-1]};
                if (sh >= {1'b0, r_dv}) begin
                    n_rem = 9'(sh - {1'b0, r_dv});
                    n_dq  = {r_dq[UW-2:0], 1'b1};
                end else begin
                    n_rem = sh[8:0];
                    n_dq  = {r_dq[UW-2:0], 1'b0};
                end
                n_bits = r_bits - 1'b1;
                if (r_bits == CW'(1)) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_OUT;
                if (r_op == OP_ON) begin
                    n_on = '0;
                    if (q != '0) begin
                        if (q > UW'(r_dash)) begin
                            c = omr_pkg::letter_of(r_scnt, r_pat);
                            n_scnt = '0;  n_pat = '0;
                        end else begin
                            is_dash = (q > UW'(r_dot));
                            if (r_scnt >= 3'(omr_pkg::MAX_SYMBOLS)) begin
                                c = omr_pkg::letter_of(r_scnt, r_pat);
                                n_scnt = '0;  n_pat = '0;
                            end
                            n_pat  = n_pat | (5'(is_dash) << n_scnt);
                            n_scnt = n_scnt + 3'd1;
                        end
                    end
                    if (c != '0) begin
                        n_c0 = c;  n_ec = 2'd1;
                    end
                    // Go on to the phrase check on the updated gap count
                    if (!r_pdone) begin
                        n_dq    = {1'b0, r_off, 1'b0} + UW'(u);
                        n_rem   = '0;
                        n_bits  = CW'(UW);
                        n_op    = OP_PHRASE;
                        n_state = S_DIV;
                    end
                end else begin
                    if (r_op == OP_OFF_LIGHT || q >= UW'(r_phrase)) begin
                        if (q != '0 && (q >= UW'(r_phrase) || q >= UW'(r_word)
                                        || q >= UW'(r_letter))) begin
                            c = omr_pkg::letter_of(r_scnt, r_pat);
                            n_scnt = '0;  n_pat = '0;
                            if (c != '0) begin
                                if (n_ec == 2'd0) begin
                                    n_c0 = c;  n_ec = 2'd1;
                                end else if (n_ec == 2'd1) begin
                                    n_c1 = c;  n_ec = 2'd2;
                                end
                            end
                            if (q >= UW'(r_phrase) || q >= UW'(r_word)) begin
                                c = (q >= UW'(r_phrase)) ? omr_pkg::CHAR_NL
                                                         : omr_pkg::CHAR_SPACE;
                                if (n_ec == 2'd0) begin
                                    n_c0 = c;  n_ec = 2'd1;
                                end else if (n_ec == 2'd1) begin
                                    n_c1 = c;  n_ec = 2'd2;
                                end
                            end
                        end
                        n_off   = '0;
                        n_pdone = (r_op == OP_PHRASE);
                    end
                end
            end
            S_OUT: begin
                if (r_ec == 2'd0) begin
                    n_state = S_IDLE;
                end else if (m_axis_tready) begin
                    if (2'(r_idx) + 2'd1 == r_ec) n_state = S_IDLE;
                    else n_idx = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state, registers and the captured sample word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;  r_op <= OP_ON;
            r_thr <= 12'd20;  r_unit <= 8'd9;  r_stable <= 4'd2;  r_dot <= 6'd2;
            r_dash <= 6'd5;  r_letter <= 6'd3;  r_word <= 6'd7;  r_phrase <= 6'd9;
            r_light <= 1'b0;  r_prev <= 1'b0;  r_pdone <= 1'b0;
            r_above <= '0;  r_below <= '0;  r_on <= '0;  r_off <= '0;
            r_pat <= '0;  r_scnt <= '0;  r_ec <= '0;  r_idx <= 1'b0;
            r_bits <= '0;
        end else begin
            r_state <= n_state;  r_op <= n_op;
            r_light <= n_light;  r_prev <= n_prev;  r_pdone <= n_pdone;
            r_above <= n_above;  r_below <= n_below;  r_on <= n_on;  r_off <= n_off;
            r_pat <= n_pat;  r_scnt <= n_scnt;  r_ec <= n_ec;  r_idx <= n_idx;
            r_bits <= n_bits;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    omr_pkg::REG_THRESHOLD: r_thr    <= i_cfg_wdata;
                    omr_pkg::REG_UNIT:      r_unit   <= i_cfg_wdata[7:0];
                    omr_pkg::REG_STABLE:    r_stable <= i_cfg_wdata[3:0];
                    omr_pkg::REG_DOT_MAX:   r_dot    <= i_cfg_wdata[5:0];
                    omr_pkg::REG_DASH_MAX:  r_dash   <= i_cfg_wdata[5:0];
                    omr_pkg::REG_LETTER:    r_letter <= i_cfg_wdata[5:0];
                    omr_pkg::REG_WORD:      r_word   <= i_cfg_wdata[5:0];
                    omr_pkg::REG_PHRASE:    r_phrase <= i_cfg_wdata[5:0];
                    default: ;
                endcase
            end
        end
        r_dq <= n_dq;  r_rem <= n_rem;  r_dv <= n_dv;
        r_c0 <= n_c0;  r_c1 <= n_c1;
        if (s_axis_tready && s_axis_tvalid) begin
            r_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_ok     <= s_axis_tuser;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/omr_checker.sv
// Port-level checker for the optical Morse receiver, bound to the top level.
// Depends on optical_morse_receiver ports only.
`timescale 1ns / 1ps
`default_nettype none
module omr_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic m_axis_tlast
);

    // No sample taken while a character word is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("sample accepted while output pending");

    // Busy after accepting a sample
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready straight after accept");

    // Nothing to send right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // After the last character the block becomes ready for the next sample
    a_last_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready after last character");

endmodule

bind optical_morse_receiver omr_checker u_omr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

FILE: tb/tb_optical_morse_receiver.sv
// Self-checking testbench for optical_morse_receiver: streams light samples
// shaped as Morse letters and noise, predicts the decoded characters and
// checks every output word. Depends on omr_pkg and the receiver RTL.
`timescale 1ns / 1ps
module tb_optical_morse_receiver;

    typedef struct packed {
        logic [11:0] level;
        logic        ok;
    } t_sample;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [11:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    optical_morse_receiver uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Register copies shared by the decoder model and the stimulus shaping
    logic [11:0] thr_q = 12'd20;
    logic [7:0]  unit_q = 8'd9;
    logic [3:0]  stable_q = 4'd2;
    logic [5:0]  dot_q = 6'd2, dash_q = 6'd5, letter_q = 6'd3, word_q = 6'd7, phrase_q = 6'd9;

    // Decoder model state
    logic        lit, was_lit, phrase_sent;
    logic [3:0]  above_cnt, below_cnt;
    logic [15:0] on_len, off_len;
    logic [4:0]  dash_bits;
    logic [2:0]  sym_cnt;
    logic [6:0]  char_buf [2];
    int          char_n;

    t_sample samples_q[$];
    t_char   chars_q[$];
    t_sample in_flight;
    int      errors = 0, n_samples = 0, n_chars = 0, n_phases = 0;
    int      src_gap = 0, snk_gap = 0;
    bit      last_phase = 0;

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void send_char(logic [6:0] c);
        if (char_n < 2) begin
            char_buf[char_n] = c;
            char_n++;
        end
    endfunction

    function automatic logic [63:0] run_units(logic [63:0] ticks);
        logic [63:0] u;
        u = (unit_q == 0) ? 64'd1 : 64'(unit_q);
        return (2 * ticks + u) / (2 * u);
    endfunction

    function automatic void close_letter();
        int         dashes;
        logic [6:0] c;
        dashes = 0;
        if (sym_cnt != 0 && sym_cnt <= omr_pkg::MAX_SYMBOLS) begin
            for (int i = 0; i < sym_cnt; i++) dashes += int'(dash_bits[i]);
            c = omr_pkg::CODE_TABLE[((1 << sym_cnt) - 2 + dash_bits) % 62];
            if (sym_cnt == omr_pkg::MAX_SYMBOLS && dashes <= 1) c = 7'd0;
            if (c != 7'd0) send_char(c);
        end
        sym_cnt = 0;
        dash_bits = 0;
    endfunction

    function automatic void end_mark(logic [63:0] ticks);
        logic [63:0] units;
        units = run_units(ticks);
        if (units < 1) return;
        if (units > dash_q) begin
            close_letter();
            return;
        end
        if (sym_cnt >= omr_pkg::MAX_SYMBOLS) close_letter();
        dash_bits[sym_cnt] = (units > dot_q);
        sym_cnt++;
    endfunction

    function automatic void end_space(logic [63:0] ticks);
        logic [63:0] units;
        units = run_units(ticks);
        if (units < 1) return;
        if (units >= phrase_q) begin
            close_letter();
            send_char(omr_pkg::CHAR_NL);
        end else if (units >= word_q) begin
            close_letter();
            send_char(omr_pkg::CHAR_SPACE);
        end else if (units >= letter_q) begin
            close_letter();
        end
    endfunction

    // Advance the model by one accepted sample and queue the characters it yields
    function automatic void decode_sample(t_sample s);
        t_char c;
        char_n = 0;
        if (s.ok) begin
            if (s.level > thr_q) begin
                if (above_cnt < omr_pkg::RUN_MAX) above_cnt++;
                below_cnt = 0;
                if (!lit && above_cnt >= stable_q) lit = 1'b1;
            end else begin
                if (below_cnt < omr_pkg::RUN_MAX) below_cnt++;
                above_cnt = 0;
                if (lit && below_cnt >= stable_q) lit = 1'b0;
            end
        end
        if (lit) begin
            if (on_len != 16'hFFFF) on_len++;
            if (!was_lit && off_len > 0) begin
                end_space(off_len);
                off_len = 0;
                phrase_sent = 1'b0;
            end
        end else begin
            if (off_len != 16'hFFFF) off_len++;
            if (was_lit && on_len > 0) begin
                end_mark(on_len);
                on_len = 0;
            end
            if (!phrase_sent && run_units(off_len) >= phrase_q) begin
                end_space(off_len);
                phrase_sent = 1'b1;
                off_len = 0;
            end
        end
        was_lit = lit;
        for (int k = 0; k < char_n; k++) begin
            c.ch = char_buf[k];
            c.last = (k == char_n - 1);
            chars_q.push_back(c);
            n_chars++;
        end
    endfunction

    // Source side: present queued samples with random idle bursts
    always @(posedge i_clk) begin
        t_sample nxt;
        bit      calm;
        if (i_rst_n) begin
            calm = last_phase && samples_q.size() < 150;
            if (s_axis_tvalid && s_axis_tready) begin
                decode_sample(in_flight);
                n_samples++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (samples_q.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(1, 9) - 1;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    nxt = samples_q.pop_front();
                    in_flight = nxt;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {4'd0, nxt.level};
                    s_axis_tuser <= nxt.ok;
                end
            end
        end
    end

    // Sink side: stall at random and check each character word
    always @(posedge i_clk) begin
        t_char want;
        bit    calm;
        if (i_rst_n) begin
            calm = last_phase && samples_q.size() < 150;
            if (m_axis_tvalid && m_axis_tready) begin
                if (chars_q.size() == 0) begin
                    report("unexpected char", m_axis_tdata, 8'd0);
                end else begin
                    want = chars_q.pop_front();
                    if (m_axis_tdata != {1'b0, want.ch})
                        report("char", m_axis_tdata, {1'b0, want.ch});
                    if (m_axis_tlast != want.last)
                        report("tlast", 8'(m_axis_tlast), 8'(want.last));
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                snk_gap = $urandom_range(1, 9) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Write all eight registers back to back and mirror them in the model
    task automatic write_regs(logic [11:0] thr, logic [7:0] unit, logic [3:0] stab,
                              logic [5:0] dot, logic [5:0] dash, logic [5:0] ltr,
                              logic [5:0] wrd, logic [5:0] phr);
        logic [11:0] vals [8];
        vals = '{thr, 12'(unit), 12'(stab), 12'(dot), 12'(dash), 12'(ltr), 12'(wrd), 12'(phr)};
        for (int r = 0; r < 8; r++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_addr <= 3'(r);
            i_cfg_wdata <= vals[r];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        thr_q = thr; unit_q = unit; stable_q = stab; dot_q = dot;
        dash_q = dash; letter_q = ltr; word_q = wrd; phrase_q = phr;
    endtask

    // Hold until every sample is taken and every character seen, then let the divider settle
    task automatic drain();
        while (samples_q.size() != 0 || s_axis_tvalid || chars_q.size() != 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        n_phases++;
    endtask

    task automatic add_sample(bit light);
        t_sample s;
        if (light && thr_q != 12'hFFF) s.level = 12'($urandom_range(thr_q + 1, 4095));
        else s.level = 12'($urandom_range(0, thr_q));
        s.ok = ($urandom_range(0, 24) != 0);
        samples_q.push_back(s);
    endtask

    task automatic add_run(bit light, int units);
        int u, j, ticks;
        u = (unit_q == 0) ? 1 : int'(unit_q);
        j = u / 3;
        ticks = units * u + $urandom_range(0, 2 * j) - j;
        if (ticks < 1) ticks = 1;
        for (int t = 0; t < ticks; t++) add_sample(light);
    endtask

    // Well-formed letters with random content, some noise pulses and raw noise bursts
    task automatic add_traffic(int n);
        int start, nsym, units, gap;
        start = samples_q.size();
        while (samples_q.size() - start < n) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 20)) begin
                    t_sample s;
                    s.level = 12'($urandom);
                    s.ok = 1'($urandom);
                    samples_q.push_back(s);
                end
            end else begin
                nsym = ($urandom_range(0, 11) == 0) ? 6 : $urandom_range(1, 5);
                for (int k = 0; k < nsym; k++) begin
                    if ($urandom_range(0, 19) == 0) units = dash_q + 2;
                    else if ($urandom_range(0, 1) || dot_q >= dash_q)
                        units = $urandom_range(1, dot_q);
                    else units = $urandom_range(dot_q + 1, dash_q);
                    if (units > 12) units = $urandom_range(1, 12);
                    add_run(1, units);
                    add_run(0, 1);
                end
                case ($urandom_range(0, 3))
                    0: gap = phrase_q;
                    1: gap = word_q;
                    default: gap = letter_q;
                endcase
                if (gap > 12) gap = $urandom_range(1, 14);
                add_run(0, gap + $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        t_sample s;
        lit = 0; was_lit = 0; phrase_sent = 0; above_cnt = 0; below_cnt = 0;
        on_len = 0; off_len = 0; dash_bits = 0; sym_cnt = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes and failed reads at the reset settings
        for (int b = 0; b < 12; b++) begin
            s.level = 12'd1 << b;
            s.ok = 1'b1;
            samples_q.push_back(s);
        end
        s = '{12'hFFF, 1'b0}; samples_q.push_back(s);
        s = '{12'd0, 1'b0};   samples_q.push_back(s);
        s = '{12'hFFF, 1'b1}; samples_q.push_back(s);
        s = '{12'd0, 1'b1};   samples_q.push_back(s);
        s = '{12'd21, 1'b1};  samples_q.push_back(s);
        s = '{12'd20, 1'b1};  samples_q.push_back(s);
        add_traffic(250);
        drain();

        write_regs(12'd0, 8'd1, 4'd1, 6'd1, 6'd3, 6'd2, 6'd4, 6'd6);
        add_traffic(300);
        drain();

        // Zero unit and zero stable count, gap thresholds out of order
        write_regs(12'd2048, 8'd0, 4'd0, 6'd1, 6'd2, 6'd5, 6'd3, 6'd2);
        add_traffic(200);
        drain();

        // Light never above threshold, then longest unit
        write_regs(12'hFFF, 8'd255, 4'd15, 6'd63, 6'd63, 6'd1, 6'd63, 6'd63);
        repeat (40) add_sample(1);
        add_run(1, 1);
        drain();

        write_regs(12'd1000, 8'd2, 4'd15, 6'd63, 6'd63, 6'd1, 6'd63, 6'd63);
        add_traffic(150);
        drain();

        write_regs(12'hAAA, 8'd3, 4'd3, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
        add_traffic(100);
        drain();

        write_regs(12'h555, 8'd2, 4'd2, 6'd1, 6'd3, 6'd3, 6'd5, 6'd7);
        last_phase = 1;
        add_traffic(350);
        drain();

        $display("covered %0d samples over %0d register settings, %0d characters checked",
                 n_samples, n_phases, n_chars);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout: %0d samples still queued", samples_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
